// ===== rtl/spwm_pkg.sv =====
// Shared types and constants for the steering PID and wheel speed mixer.
// Used by spwm_ctrl, spwm_datapath and steering_pid_wheel_mix_top.
`default_nettype none

package spwm_pkg;

    // Field widths fixed by the interface.
    localparam int ERR_W       = 24;
    localparam int GAIN_W      = 31;
    localparam int SPEED_W     = 10;
    localparam int STEER_OUT_W = 22;
    localparam int WHEEL_W     = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 31;

    // Integral sum holds up to four error terms.
    localparam int SUM_W  = ERR_W + 2;
    localparam int DIFF_W = ERR_W + 1;
    localparam int MUL_W  = 32;
    localparam int ACC_W  = 64;

    // Divide by 17 for values up to 1020: floor(t * 3856 / 2^16).
    localparam int RECIP17       = 3856;
    localparam int RECIP17_W     = 12;
    localparam int RECIP17_SHIFT = 16;
    localparam int SCALED_W      = 10;
    localparam int RAISE_W       = 6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HEADING_KP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADING_KI = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADING_KD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LATERAL_KP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LATERAL_KI = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LATERAL_KD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED = 3'd6;

    localparam logic [SPEED_W-1:0] BASE_SPEED_RESET = 10'd100;

    // Loop select codes.
    localparam logic ACT_HEADING = 1'b0;
    localparam logic ACT_LATERAL = 1'b1;

    typedef struct packed {
        logic                    action;
        logic signed [ERR_W-1:0] error_value;
    } in_item_t;

    typedef struct packed {
        logic signed [STEER_OUT_W-1:0] steering;
        logic [WHEEL_W-1:0]            left_pair_speed;
        logic [WHEEL_W-1:0]            right_pair_speed;
    } out_item_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  heading_kp;
        logic [GAIN_W-1:0]  heading_ki;
        logic [GAIN_W-1:0]  heading_kd;
        logic [GAIN_W-1:0]  lateral_kp;
        logic [GAIN_W-1:0]  lateral_ki;
        logic [GAIN_W-1:0]  lateral_kd;
        logic [SPEED_W-1:0] base_speed;
    } cfg_regs_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_ACC,
        ST_STEER,
        ST_SCALE,
        ST_MIX
    } ctrl_state_t;

    typedef enum logic [1:0] {
        SEL_P,
        SEL_I,
        SEL_D
    } mul_sel_t;

    typedef struct packed {
        logic     cap_in;
        logic     prep;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_en;
        logic     acc_first;
        logic     steer_en;
        logic     scale_en;
        logic     load_out;
    } dp_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/spwm_ctrl.sv =====
// Controller state machine that sequences one item through the datapath.
// Depends on spwm_pkg for the state enum and the command struct.
`default_nettype none

module spwm_ctrl
    import spwm_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    output dp_cmd_t      cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;
    logic        accept;

    // The output register is free when empty or being emptied this cycle.
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) || ((state_reg == ST_MIX) && out_free);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:  state_next = ST_MUL_P;
            ST_MUL_P: state_next = ST_MUL_I;
            ST_MUL_I: state_next = ST_MUL_D;
            ST_MUL_D: state_next = ST_ACC;
            ST_ACC:   state_next = ST_STEER;
            ST_STEER: state_next = ST_SCALE;
            ST_SCALE: state_next = ST_MIX;
            ST_MIX:
            begin
                if (out_free)
                begin
                    state_next = accept ? ST_PREP : ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Datapath commands.
    always_comb
    begin
        cmd           = '0;
        cmd.mul_sel   = SEL_P;
        cmd.cap_in    = accept;
        unique case (state_reg)
            ST_IDLE:  ;
            ST_PREP:  cmd.prep = 1'b1;
            ST_MUL_P:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = SEL_P;
            end
            ST_MUL_I:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = SEL_I;
                cmd.acc_en    = 1'b1;
                cmd.acc_first = 1'b1;
            end
            ST_MUL_D:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = SEL_D;
                cmd.acc_en  = 1'b1;
            end
            ST_ACC:   cmd.acc_en   = 1'b1;
            ST_STEER: cmd.steer_en = 1'b1;
            ST_SCALE: cmd.scale_en = 1'b1;
            ST_MIX:   cmd.load_out = out_free;
            default:  ;
        endcase
    end

    // Output valid flag.
    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // An accepted item always starts its preparation step next.
    a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_PREP)
        else $error("accepted item did not enter preparation");

    // A waiting result is never overwritten.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("output register loaded while still occupied");

    // A result appears only after the mixing step.
    a_valid_from_mix: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_MIX))
        else $error("output became valid outside the mixing step");

endmodule

`default_nettype wire

// ===== rtl/spwm_datapath.sv =====
// Datapath: loop state, shared 32x32 multiplier, accumulator, clamp and mixer.
// Depends on spwm_pkg for field widths, payload structs and command struct.
`default_nettype none

module spwm_datapath
    import spwm_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire dp_cmd_t   cmd,
    input  wire in_item_t  in_data,
    input  wire cfg_regs_t cfg,
    output out_item_t      out_data
);

    localparam int STEER_W  = FRAC_BITS + 6;
    localparam int MAG_W    = FRAC_BITS + 5;
    localparam int SCALE_PW = MAG_W + 6;
    localparam logic signed [31:0]    TEN     = 32'(10) << FRAC_BITS;
    localparam logic signed [ACC_W-1:0] LIM   = 64'(17) << FRAC_BITS;
    localparam logic signed [SUM_W-1:0] SUM_MAX = 26'sd8388607;
    localparam logic signed [SUM_W-1:0] SUM_MIN = -26'sd8388608;

    // Loop state.
    logic signed [ERR_W-1:0] h_last_reg, h_int_reg;
    logic signed [ERR_W-1:0] l_last_reg, l_old_reg, l_int_reg;

    // Per-item working registers.
    logic                    action_reg;
    logic signed [ERR_W-1:0] e_reg;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [MUL_W-1:0] dterm_reg, dterm_next;
    logic signed [ACC_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [STEER_W-1:0] steer_reg, steer_next;
    logic [SCALED_W-1:0]     t_reg, t_next;
    out_item_t               out_reg, out_next;

    logic signed [DIFF_W-1:0] diff;
    logic signed [MUL_W-1:0]  diff_w;
    logic signed [31:0]       sum_w;
    logic                     keep;
    logic signed [ERR_W-1:0]  sat_sum;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic [GAIN_W-1:0]        gain;
    logic signed [ACC_W-1:0]  shifted;
    logic [MAG_W-1:0]         mag;
    logic [SCALE_PW-1:0]      scaled;
    logic [SCALED_W+RECIP17_W-1:0] recip_prod;
    logic [RAISE_W-1:0]       raise;
    logic signed [ACC_W-1:0]  steer_wide;

    // Integral sum and error difference for the selected loop.
    always_comb
    begin
        if (action_reg == ACT_HEADING)
        begin
            sum_next = {{2{h_int_reg[ERR_W-1]}}, h_int_reg}
                     + {{2{e_reg[ERR_W-1]}}, e_reg};
            diff     = {e_reg[ERR_W-1], e_reg} - {h_last_reg[ERR_W-1], h_last_reg};
            diff_w   = {{(MUL_W-DIFF_W){diff[DIFF_W-1]}}, diff};
            dterm_next = diff_w;
        end
        else
        begin
            sum_next = {{2{l_int_reg[ERR_W-1]}}, l_int_reg}
                     + {{2{l_old_reg[ERR_W-1]}}, l_old_reg}
                     + {{2{l_last_reg[ERR_W-1]}}, l_last_reg}
                     + {{2{e_reg[ERR_W-1]}}, e_reg};
            diff     = {e_reg[ERR_W-1], e_reg} - {l_last_reg[ERR_W-1], l_last_reg};
            diff_w   = {{(MUL_W-DIFF_W){diff[DIFF_W-1]}}, diff};
            // Times 50 as 32 + 16 + 2.
            dterm_next = (diff_w <<< 5) + (diff_w <<< 4) + (diff_w <<< 1);
        end
    end

    // The integral is kept only while its magnitude stays below ten.
    always_comb
    begin
        sum_w = {{(32-SUM_W){sum_next[SUM_W-1]}}, sum_next};
        keep  = (sum_w < TEN) && (sum_w > -TEN);
        priority if (sum_next > SUM_MAX)
        begin
            sat_sum = 24'sh7FFFFF;
        end
        else if (sum_next < SUM_MIN)
        begin
            sat_sum = 24'sh800000;
        end
        else
        begin
            sat_sum = sum_next[ERR_W-1:0];
        end
    end

    // Multiplier operand selection.
    always_comb
    begin
        unique case (cmd.mul_sel)
            SEL_P:
            begin
                mul_a = {{(MUL_W-ERR_W){e_reg[ERR_W-1]}}, e_reg};
                gain  = (action_reg == ACT_HEADING) ? cfg.heading_kp : cfg.lateral_kp;
            end
            SEL_I:
            begin
                mul_a = {{(MUL_W-SUM_W){sum_reg[SUM_W-1]}}, sum_reg};
                gain  = (action_reg == ACT_HEADING) ? cfg.heading_ki : cfg.lateral_ki;
            end
            SEL_D:
            begin
                mul_a = dterm_reg;
                gain  = (action_reg == ACT_HEADING) ? cfg.heading_kd : cfg.lateral_kd;
            end
            default:
            begin
                mul_a = '0;
                gain  = '0;
            end
        endcase
        mul_b     = {1'b0, gain};
        prod_next = mul_a * mul_b;
        acc_next  = cmd.acc_first ? prod_reg : (acc_reg + prod_reg);
    end

    // Drop the fraction (floor) and clamp to plus or minus 17.
    always_comb
    begin
        shifted = acc_reg >>> FRAC_BITS;
        priority if (shifted > LIM)
        begin
            steer_next = STEER_W'(LIM);
        end
        else if (shifted < -LIM)
        begin
            steer_next = STEER_W'(-LIM);
        end
        else
        begin
            steer_next = STEER_W'(shifted);
        end
    end

    // Scale the magnitude by 60 and drop the fraction.
    always_comb
    begin
        mag    = steer_reg[STEER_W-1] ? MAG_W'(-steer_reg) : MAG_W'(steer_reg);
        scaled = ({6'b0, mag} << 6) - ({6'b0, mag} << 2);
        t_next = scaled[FRAC_BITS+SCALED_W-1:FRAC_BITS];
    end

    // Divide by 17 and raise one wheel pair.
    always_comb
    begin
        recip_prod = t_reg * RECIP17_W'(RECIP17);
        raise      = recip_prod[RECIP17_SHIFT+RAISE_W-1:RECIP17_SHIFT];
        steer_wide = steer_reg;
        out_next.steering         = steer_wide[STEER_OUT_W-1:0];
        out_next.left_pair_speed  = WHEEL_W'(cfg.base_speed);
        out_next.right_pair_speed = WHEEL_W'(cfg.base_speed);
        if (cfg.base_speed != '0)
        begin
            if (steer_reg < 0)
            begin
                out_next.left_pair_speed = WHEEL_W'(cfg.base_speed) + WHEEL_W'(raise);
            end
            else
            begin
                out_next.right_pair_speed = WHEEL_W'(cfg.base_speed) + WHEEL_W'(raise);
            end
        end
    end

    // Loop state updates at the preparation step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_last_reg <= '0;
            h_int_reg  <= '0;
            l_last_reg <= '0;
            l_old_reg  <= '0;
            l_int_reg  <= '0;
        end
        else if (cmd.prep)
        begin
            if (action_reg == ACT_HEADING)
            begin
                h_last_reg <= e_reg;
                if (keep)
                begin
                    h_int_reg <= sat_sum;
                end
            end
            else
            begin
                l_old_reg  <= l_last_reg;
                l_last_reg <= e_reg;
                if (keep)
                begin
                    l_int_reg <= sat_sum;
                end
            end
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.cap_in)
        begin
            action_reg <= in_data.action;
            e_reg      <= in_data.error_value;
        end
        if (cmd.prep)
        begin
            sum_reg   <= sum_next;
            dterm_reg <= dterm_next;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.acc_en)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.steer_en)
        begin
            steer_reg <= steer_next;
        end
        if (cmd.scale_en)
        begin
            t_reg <= t_next;
        end
        if (cmd.load_out)
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

    // The clamp keeps the steering within plus or minus 17.
    a_steer_range: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.steer_en) |-> (STEER_W'(LIM) >= steer_reg) && (steer_reg >= -STEER_W'(LIM)))
        else $error("steering outside clamp range");

    // A stored heading integral always has magnitude below ten.
    a_h_int_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ($signed({{(32-ERR_W){h_int_reg[ERR_W-1]}}, h_int_reg}) < TEN)
        && ($signed({{(32-ERR_W){h_int_reg[ERR_W-1]}}, h_int_reg}) > -TEN))
        else $error("heading integral out of bound");

    // The scaled magnitude never exceeds 60 times 17.
    a_scaled_bound: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.scale_en) |-> t_reg <= 10'd1020)
        else $error("scaled steering magnitude out of range");

endmodule

`default_nettype wire

// ===== rtl/steering_pid_wheel_mix_top.sv =====
// Top level of the steering PID and wheel speed mixer: configuration
// registers plus spwm_ctrl and spwm_datapath. Depends on spwm_pkg.
//
//  Channel   Signals                          Direction  Payload
//  in        in_valid, in_ready, in_data      input      in_item_t
//  out       out_valid, out_ready, out_data   output     out_item_t
//  cfg       cfg_write, cfg_index, cfg_data   input      31-bit register write
//
// Each item goes from its transfer to its result being held in the output
// register through one preparation step, three passes through the shared
// 32x32 multiplier, one accumulate, clamp, scale and divide-by-17 mix.
// A new item is taken only when idle or at the mixing step, so items do not
// overlap: the next one is taken in the cycle that loads the output register.
// Reset clears the loop state and sets base speed to 100, gains to zero.
// A stalled output holds the block at its mixing step until the result leaves.
`default_nettype none

module steering_pid_wheel_mix_top
    import spwm_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire in_item_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output out_item_t                  out_data,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_regs_t cfg_reg;
    dp_cmd_t   cmd;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.heading_kp <= '0;
            cfg_reg.heading_ki <= '0;
            cfg_reg.heading_kd <= '0;
            cfg_reg.lateral_kp <= '0;
            cfg_reg.lateral_ki <= '0;
            cfg_reg.lateral_kd <= '0;
            cfg_reg.base_speed <= BASE_SPEED_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_HEADING_KP: cfg_reg.heading_kp <= cfg_data;
                CFG_HEADING_KI: cfg_reg.heading_ki <= cfg_data;
                CFG_HEADING_KD: cfg_reg.heading_kd <= cfg_data;
                CFG_LATERAL_KP: cfg_reg.lateral_kp <= cfg_data;
                CFG_LATERAL_KI: cfg_reg.lateral_ki <= cfg_data;
                CFG_LATERAL_KD: cfg_reg.lateral_kd <= cfg_data;
                CFG_BASE_SPEED: cfg_reg.base_speed <= cfg_data[SPEED_W-1:0];
                default:        ;
            endcase
        end
    end

    spwm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    spwm_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .cfg      (cfg_reg),
        .out_data (out_data)
    );

endmodule

`default_nettype wire
